// ===== rtl/segmented_overflow_queue_core_defines.svh =====
`ifndef SEGMENTED_OVERFLOW_QUEUE_CORE_DEFINES_SVH
`define SEGMENTED_OVERFLOW_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SOQ_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define SOQ_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/soq_pkg.sv =====
package soq_pkg;

    localparam int SEGMENTS_DEF  = 8;
    localparam int SEG_DEPTH_DEF = 8;
    localparam int CAP_W         = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] value;
    } soq_in_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic               was_empty;
        logic               dropped;
    } soq_out_t;

    typedef struct packed {
        logic start;
        logic meta_rd;
        logic step;
        logic commit;
        logic miss;
        logic grab;
        logic publish;
    } soq_cmd_t;

    typedef struct packed {
        logic hit;
        logic last_seg;
        logic is_pop;
        logic out_free;
    } soq_stat_t;

endpackage

// ===== rtl/soq_ctrl.sv =====
module soq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  soq_pkg::soq_stat_t stat,
    output soq_pkg::soq_cmd_t  cmd
);
    import soq_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.meta_rd = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.hit)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.is_pop ? ST_FETCH : ST_DONE;
                end
                else if (stat.last_seg)
                begin
                    cmd.miss   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_FETCH:
            begin
                cmd.grab   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/soq_dpath.sv =====
`include "segmented_overflow_queue_core_defines.svh"

module soq_dpath #(
    parameter int SEGMENTS  = soq_pkg::SEGMENTS_DEF,
    parameter int SEG_DEPTH = soq_pkg::SEG_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [soq_pkg::CAP_W-1:0]   cfg_wdata,
    input  soq_pkg::soq_in_t            in_data,
    input  soq_pkg::soq_cmd_t           cmd,
    output soq_pkg::soq_stat_t          stat,
    input  logic                        out_ready,
    output logic                        out_valid,
    output soq_pkg::soq_out_t           out_data
);
    import soq_pkg::*;

    localparam int SW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int HW   = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
    localparam int CW   = $clog2(SEG_DEPTH + 1);
    localparam int EN   = SEGMENTS * SEG_DEPTH;
    localparam int AW   = (EN > 1) ? $clog2(EN) : 1;
    localparam int MW   = (CAP_W > CW) ? CAP_W : CW;
    localparam int SUMW = CW + 1;

    typedef struct packed {
        logic [HW-1:0] head;
        logic [CW-1:0] cnt;
    } meta_t;

    logic [CAP_W-1:0]   cap_reg;
    logic               op_reg;
    logic signed [31:0] value_reg;
    logic [SW-1:0]      seg_reg;
    logic [SEGMENTS-1:0] meta_vld_reg;
    logic               rd_vld_reg;
    meta_t              meta_rd_reg;
    logic [31:0]        entry_rd_reg;
    soq_out_t           res_reg;
    logic               out_valid_reg;
    soq_out_t           out_data_reg;

    meta_t              meta_mem [SEGMENTS];
    logic [31:0]        entry_mem [EN];

    logic [MW-1:0]      cap_x;
    logic [MW-1:0]      depth_x;
    logic [MW-1:0]      cap_eff;
    logic [HW-1:0]      cur_head;
    logic [CW-1:0]      cur_cnt;
    logic [SUMW-1:0]    sum;
    logic [SUMW-1:0]    sum_wrap;
    logic [HW-1:0]      tail;
    logic [HW-1:0]      head_nx;
    logic [HW-1:0]      slot;
    logic [AW-1:0]      addr;
    meta_t              meta_new;

    assign cap_x    = MW'(cap_reg);
    assign depth_x  = MW'(SEG_DEPTH);
    assign cap_eff  = (cap_x > depth_x) ? depth_x : cap_x;

    assign cur_head = rd_vld_reg ? meta_rd_reg.head : '0;
    assign cur_cnt  = rd_vld_reg ? meta_rd_reg.cnt : '0;

    assign sum      = SUMW'(cur_head) + SUMW'(cur_cnt);
    assign sum_wrap = (sum >= SUMW'(SEG_DEPTH)) ? (sum - SUMW'(SEG_DEPTH)) : sum;
    assign tail     = HW'(sum_wrap);
    assign head_nx  = (cur_head == HW'(SEG_DEPTH - 1)) ? '0 : (cur_head + 1'b1);

    assign slot     = (op_reg == OP_POP) ? cur_head : tail;
    assign addr     = AW'(seg_reg) * AW'(SEG_DEPTH) + AW'(slot);

    always_comb
    begin
        if (op_reg == OP_POP)
        begin
            meta_new.head = head_nx;
            meta_new.cnt  = cur_cnt - 1'b1;
        end
        else
        begin
            meta_new.head = cur_head;
            meta_new.cnt  = cur_cnt + 1'b1;
        end
    end

    assign stat.hit      = (op_reg == OP_POP) ? (cur_cnt != '0) : (MW'(cur_cnt) < cap_eff);
    assign stat.last_seg = (seg_reg == SW'(SEGMENTS - 1));
    assign stat.is_pop   = (op_reg == OP_POP);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            seg_reg       <= '0;
            meta_vld_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.start)
            begin
                seg_reg <= '0;
            end
            else if (cmd.step)
            begin
                seg_reg <= seg_reg + 1'b1;
            end
            if (cmd.meta_rd)
            begin
                rd_vld_reg <= meta_vld_reg[seg_reg];
            end
            if (cmd.commit)
            begin
                meta_vld_reg[seg_reg] <= 1'b1;
            end
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= in_data.operation;
            value_reg <= in_data.value;
        end
        if (cmd.meta_rd)
        begin
            meta_rd_reg <= meta_mem[seg_reg];
        end
        if (cmd.commit)
        begin
            meta_mem[seg_reg] <= meta_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == OP_PUSH))
        begin
            entry_mem[addr] <= value_reg;
        end
        if (cmd.commit && (op_reg == OP_POP))
        begin
            entry_rd_reg <= entry_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && (op_reg == OP_PUSH))
        begin
            res_reg <= '0;
        end
        else if (cmd.miss)
        begin
            res_reg.popped_value <= '0;
            res_reg.was_empty    <= (op_reg == OP_POP);
            res_reg.dropped      <= (op_reg == OP_PUSH);
        end
        else if (cmd.grab)
        begin
            res_reg.popped_value <= entry_rd_reg;
            res_reg.was_empty    <= 1'b0;
            res_reg.dropped      <= 1'b0;
        end
        if (cmd.publish)
        begin
            out_data_reg <= res_reg;
        end
    end

    `SOQ_ASSERT_IMP(a_cnt_bound, cmd.commit, MW'(cur_cnt) <= depth_x, "segment count past depth")
    `SOQ_ASSERT_IMP(a_push_room, cmd.commit && (op_reg == OP_PUSH), MW'(cur_cnt) < cap_eff, "push into full segment")
    `SOQ_ASSERT_IMP(a_scan_end, cmd.step, seg_reg != SW'(SEGMENTS - 1), "scan ran past last segment")
    `SOQ_ASSERT_IMP(a_pub_free, cmd.publish, !out_valid_reg || out_ready, "result overwritten before taken")
    `SOQ_ASSERT_NXT(a_pub_valid, cmd.publish, out_valid_reg, "published result not shown")

endmodule

// ===== rtl/segmented_overflow_queue_core.sv =====
// Flow: an accepted request scans the per-segment head/count memory from segment 0, one
// registered read and check per segment, until a push finds a segment below capacity or a
// pop a non-empty one, or the last segment misses (overflow or empty pop); a pop then fetches
// its entry. A new request is taken only once the previous result has been published.
// Reset (async, active low): controller idle, segment valid bits cleared so every segment
// reads empty, capacity back to 5; the entry store is not cleared and needs no clearing pass.
module segmented_overflow_queue_core #(
    parameter int SEGMENTS  = soq_pkg::SEGMENTS_DEF,
    parameter int SEG_DEPTH = soq_pkg::SEG_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [soq_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  soq_pkg::soq_in_t          in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output soq_pkg::soq_out_t         out_data
);
    import soq_pkg::*;

    soq_cmd_t  cmd;
    soq_stat_t stat;

    soq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    soq_dpath #(
        .SEGMENTS  (SEGMENTS),
        .SEG_DEPTH (SEG_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule
